@@ hw/rtl/tbdro_pkg.sv @@
`default_nettype none
package tbdro_pkg;

  localparam int DIV_W = 52;
  localparam int DEN_W = 33;
  localparam int DIV_CW = 6;
  localparam int X_W = 52;
  localparam int Z_W = 34;
  localparam int IT_W = 5;

  localparam logic [31:0] TRACK_RESET = 32'd39322;
  localparam logic [31:0] BAM_K = 32'd341782638;
  localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] atan_bam(input logic [IT_W-1:0] k);
    logic [31:0] v;
    case (k)
      5'd0: v = 32'h20000000;
      5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;
      5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;
      5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // signed saturation of a magnitude quotient
  function automatic logic [31:0] sat_quo(input logic [DIV_W-1:0] q, input logic neg,
                                         input logic zero);
    logic [31:0] r;
    if (zero) begin
      r = 32'd0;
    end else if (neg) begin
      if (q > DIV_W'(64'h80000000)) r = 32'h80000000;
      else r = 32'd0 - q[31:0];
    end else begin
      if (q > DIV_W'(64'h7FFFFFFF)) r = 32'h7FFFFFFF;
      else r = q[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tbdro_if.sv @@
`default_nettype none
interface tbdro_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fwd_disp_a;
  logic signed [31:0] fwd_disp_b;
  logic signed [31:0] left_disp_a;
  logic signed [31:0] right_disp_a;
  logic signed [31:0] left_disp_b;
  logic signed [31:0] right_disp_b;
  logic        [23:0] interval;
  modport source (output valid, fwd_disp_a, fwd_disp_b, left_disp_a, right_disp_a,
                  left_disp_b, right_disp_b, interval, input ready);
  modport sink (input valid, fwd_disp_a, fwd_disp_b, left_disp_a, right_disp_a,
                left_disp_b, right_disp_b, interval, output ready);
endinterface

interface tbdro_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [31:0] heading;
  logic signed [31:0] fwd_velocity;
  logic signed [31:0] turn_term;
  modport source (output valid, pos_x, pos_y, heading, fwd_velocity, turn_term,
                  input ready);
  modport sink (input valid, pos_x, pos_y, heading, fwd_velocity, turn_term,
                output ready);
endinterface

interface tbdro_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] track_width;
  modport source (output valid, track_width, input ready);
  modport sink (input valid, track_width, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tbdro_div.sv @@
`default_nettype none
module tbdro_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tbdro_pkg::div_req_t req,
  output tbdro_pkg::div_rsp_t      rsp
);

  logic [tbdro_pkg::DEN_W-1:0]  rem;
  logic [tbdro_pkg::DEN_W-1:0]  den;
  logic [tbdro_pkg::DIV_W-1:0]  quo;
  logic [tbdro_pkg::DIV_CW-1:0] cnt;
  logic                         busy;
  logic                         done;
  logic [tbdro_pkg::DEN_W+1:0]  trial;

  assign trial = {1'b0, rem, quo[tbdro_pkg::DIV_W-1]} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        if (!trial[tbdro_pkg::DEN_W+1]) begin
          rem <= trial[tbdro_pkg::DEN_W-1:0];
          quo <= {quo[tbdro_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem <= {rem[tbdro_pkg::DEN_W-2:0], quo[tbdro_pkg::DIV_W-1]};
          quo <= {quo[tbdro_pkg::DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == tbdro_pkg::DIV_CW'(tbdro_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
`default_nettype wire

@@ hw/rtl/twin_base_dead_reckoning_odometry.sv @@
// Dead-reckoning odometry for two differential drive bases.
// req (sink): one odometry report per item: forward and wheel displacements of
//   both bases plus the interval since the last report.
// rsp (source): one item per report: accumulated position and heading, the
//   x velocity and the mean turn value.
// cfg (sink): writes track_width; always ready, write only while idle.
// Each item takes two passes of the shared radix-2 divider (turn value,
// velocity), four passes of the shared 33x33 multiplier and CORDIC_STEPS
// CORDIC iterations, one CORDIC iteration per cycle.
// req.ready is high only while the sequencer is idle; the next item may be
// taken while the previous result still waits in the output register.
// If the receiver stalls, the finished item waits in the sequencer until the
// output register frees up.
// Reset clears position and heading to zero and sets track_width to 0.6 m.
`default_nettype none
module twin_base_dead_reckoning_odometry #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tbdro_in_if.sink    req,
  tbdro_out_if.source rsp,
  tbdro_cfg_if.sink   cfg
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TDIV  = 4'd1;
  localparam logic [3:0] S_TWAIT = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_M2    = 4'd4;
  localparam logic [3:0] S_M3    = 4'd5;
  localparam logic [3:0] S_M4    = 4'd6;
  localparam logic [3:0] S_M5    = 4'd7;
  localparam logic [3:0] S_ROT   = 4'd8;
  localparam logic [3:0] S_VDIV  = 4'd9;
  localparam logic [3:0] S_VWAIT = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic [tbdro_pkg::IT_W-1:0] LAST = tbdro_pkg::IT_W'(CORDIC_STEPS - 1);

  logic [3:0]  state;
  logic [31:0] track_width;
  logic [31:0] acc_x;
  logic [31:0] acc_y;
  logic [31:0] acc_heading;

  logic signed [31:0] step;
  logic signed [33:0] diff;
  logic [23:0]        dt;
  logic [31:0]        turn;
  logic [31:0]        vel;
  logic [31:0]        prod_hi;
  logic [31:0]        lo_part;
  logic [31:0]        half;
  logic [31:0]        head1;
  logic               neg;
  logic               zero;

  logic signed [tbdro_pkg::X_W-1:0] x;
  logic signed [tbdro_pkg::X_W-1:0] y;
  logic signed [tbdro_pkg::Z_W-1:0] z;
  logic [tbdro_pkg::IT_W-1:0]       iter;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_r;

  logic                out_valid;
  logic signed [31:0]  o_x;
  logic signed [31:0]  o_y;
  logic        [31:0]  o_head;
  logic signed [31:0]  o_vel;
  logic signed [31:0]  o_turn;

  tbdro_pkg::div_req_t div_req;
  tbdro_pkg::div_rsp_t div_rsp;

  logic [33:0]                      diff_abs;
  logic signed [35:0]               xx;
  logic [35:0]                      xx_abs;
  logic [31:0]                      half_c;
  logic [31:0]                      quad;
  logic signed [tbdro_pkg::X_W-1:0] x0;
  logic signed [tbdro_pkg::X_W-1:0] dx;
  logic signed [tbdro_pkg::X_W-1:0] dy;
  logic [31:0]                      sat_r;

  assign diff_abs = diff[33] ? 34'd0 - diff : diff;
  assign xx       = x[51:16];
  assign xx_abs   = xx[35] ? 36'd0 - xx : xx;
  assign half_c   = lo_part + mul_r[31:0];
  assign quad     = head1 + 32'h40000000;
  assign x0       = {{4{mul_r[65]}}, mul_r[63:16]};
  assign dx       = y >>> iter;
  assign dy       = x >>> iter;
  assign sat_r    = tbdro_pkg::sat_quo(div_rsp.quo, neg, zero);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1: begin
        mul_a = {turn[31], turn};
        mul_b = {9'd0, dt};
      end
      S_M2: begin
        mul_a = {1'b0, mul_r[31:0]};
        mul_b = {1'b0, tbdro_pkg::BAM_K};
      end
      S_M3: begin
        mul_a = {prod_hi[31], prod_hi};
        mul_b = {1'b0, tbdro_pkg::BAM_K};
      end
      S_M4: begin
        mul_a = {step[31], step};
        mul_b = {1'b0, tbdro_pkg::CORDIC_GAIN};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start = (state == S_TDIV) || (state == S_VDIV);
    if (state == S_TDIV) begin
      div_req.num = {2'b00, diff_abs, 16'd0};
      div_req.den = {track_width, 1'b0};
    end else begin
      div_req.num = {xx_abs, 16'd0};
      div_req.den = {9'd0, dt};
    end
  end

  tbdro_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      track_width <= tbdro_pkg::TRACK_RESET;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        track_width <= cfg.track_width;
      end
      if (rsp.valid && rsp.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            step  <= 32'(({req.fwd_disp_a[31], req.fwd_disp_a}
                          + {req.fwd_disp_b[31], req.fwd_disp_b}) >>> 1);
            diff  <= ({{2{req.left_disp_a[31]}}, req.left_disp_a}
                      - {{2{req.right_disp_a[31]}}, req.right_disp_a})
                     + ({{2{req.left_disp_b[31]}}, req.left_disp_b}
                        - {{2{req.right_disp_b[31]}}, req.right_disp_b});
            dt    <= req.interval;
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          neg   <= diff[33];
          zero  <= (diff == '0);
          state <= S_TWAIT;
        end
        S_TWAIT: begin
          if (div_rsp.done) begin
            turn  <= sat_r;
            state <= S_M1;
          end
        end
        S_M1: begin
          state <= S_M2;
        end
        S_M2: begin
          prod_hi <= mul_r[63:32];
          state   <= S_M3;
        end
        S_M3: begin
          lo_part <= mul_r[63:32];
          state   <= S_M4;
        end
        S_M4: begin
          half  <= half_c;
          head1 <= acc_heading + half_c;
          state <= S_M5;
        end
        S_M5: begin
          // fold the angle into the right half plane
          if (quad[31]) begin
            x <= -x0;
            z <= tbdro_pkg::Z_W'(signed'(head1 + 32'h80000000));
          end else begin
            x <= x0;
            z <= tbdro_pkg::Z_W'(signed'(head1));
          end
          y     <= '0;
          iter  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (!z[tbdro_pkg::Z_W-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - signed'({2'b00, tbdro_pkg::atan_bam(iter)});
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + signed'({2'b00, tbdro_pkg::atan_bam(iter)});
          end
          iter <= iter + 1'b1;
          if (iter == LAST) begin
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          acc_x       <= acc_x + x[47:16];
          acc_y       <= acc_y + y[47:16];
          acc_heading <= head1 + half;
          neg         <= xx[35];
          zero        <= (xx == '0);
          state       <= S_VWAIT;
        end
        S_VWAIT: begin
          if (div_rsp.done) begin
            vel   <= sat_r;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            o_x       <= acc_x;
            o_y       <= acc_y;
            o_head    <= acc_heading;
            o_vel     <= vel;
            o_turn    <= turn;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign rsp.valid        = out_valid;
  assign rsp.pos_x        = o_x;
  assign rsp.pos_y        = o_y;
  assign rsp.heading      = o_head;
  assign rsp.fwd_velocity = o_vel;
  assign rsp.turn_term    = o_turn;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_TDIV)
    else $error("sequencer did not start on accepted item");

  a_rot_end: assert property (@(posedge clk) disable iff (rst)
    state == S_ROT && iter == LAST |=> state == S_VDIV)
    else $error("rotation did not end after the last iteration");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_TWAIT || state == S_VWAIT)
    else $error("divider finished outside a wait state");
`endif

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
module testbench;

  localparam int STEPS = 24;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    int        fa, fb, la, ra, lb, rb;
    bit [23:0] dt;
  } report_t;

  typedef struct {
    bit [31:0] x, y, head, vel, turn;
  } pose_t;

  class odometry_scoreboard;
    bit [31:0] width;
    bit [31:0] acc_x, acc_y, acc_head;
    pose_t     pending[$];
    int        errors, checked;
    bit [31:0] arctan[32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

    function void clear();
      width = tbdro_pkg::TRACK_RESET;
      acc_x = 0;
      acc_y = 0;
      acc_head = 0;
    endfunction

    function longint div_clip(longint num, longint den);
      longint q;
      if (den == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
      q = num / den;
      if (q > 64'sd2147483647) return 64'sd2147483647;
      if (q < -64'sd2147483648) return -64'sd2147483648;
      return q;
    endfunction

    function void rotate_step(longint step, bit [31:0] ang, output longint ox,
                              output longint oy);
      longint x, y, z, dx, dy;
      bit [31:0] shifted;
      x = (step * 64'sd2608131496) >>> 16;
      y = 0;
      shifted = ang + 32'h40000000;
      if (shifted >= 32'h80000000) begin
        x = -x;
        ang = ang + 32'h80000000;
      end
      z = longint'($signed(ang));
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> (i % 32);
        dy = x >>> (i % 32);
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= longint'(arctan[i % 32]);
        end else begin
          x += dx;
          y -= dy;
          z += longint'(arctan[i % 32]);
        end
      end
      ox = x >>> 16;
      oy = y >>> 16;
    endfunction

    function void note(report_t r);
      longint step, diff, turn, xx, yy, vel;
      longint unsigned prod, k;
      bit [31:0] half;
      pose_t p;
      k = 64'd341782638;
      step = (longint'(r.fa) + longint'(r.fb)) >>> 1;
      diff = (longint'(r.la) - longint'(r.ra)) + (longint'(r.lb) - longint'(r.rb));
      turn = div_clip(diff * 65536, 2 * longint'(width));
      prod = longint'(turn * longint'(r.dt));
      half = 32'((prod >> 32) * k + (((prod & 64'hFFFFFFFF) * k) >> 32));
      acc_head += half;
      rotate_step(step, acc_head, xx, yy);
      acc_head += half;
      vel = div_clip(xx * 65536, longint'(r.dt));
      acc_x += 32'(xx);
      acc_y += 32'(yy);
      p.x = acc_x;
      p.y = acc_y;
      p.head = acc_head;
      p.vel = 32'(vel);
      p.turn = 32'(turn);
      pending.push_back(p);
    endfunction

    function void check(pose_t got);
      pose_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) begin
        $error("pos_x expected %h actual %h", e.x, got.x);
        errors++;
      end
      if (got.y !== e.y) begin
        $error("pos_y expected %h actual %h", e.y, got.y);
        errors++;
      end
      if (got.head !== e.head) begin
        $error("heading expected %h actual %h", e.head, got.head);
        errors++;
      end
      if (got.vel !== e.vel) begin
        $error("fwd_velocity expected %h actual %h", e.vel, got.vel);
        errors++;
      end
      if (got.turn !== e.turn) begin
        $error("turn_term expected %h actual %h", e.turn, got.turn);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  tbdro_in_if  req ();
  tbdro_out_if rsp ();
  tbdro_cfg_if cfg ();

  twin_base_dead_reckoning_odometry dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  odometry_scoreboard odo = new();
  int     gap_pct, stall_pct, sent;
  bit     hold;
  longint cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("twin_base_dead_reckoning_odometry: mismatch");
      $finish;
    end
  end

  always @(negedge clk) rsp.ready <= !rst && !hold && ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    pose_t p;
    if (!rst && rsp.valid && rsp.ready) begin
      p.x = rsp.pos_x;
      p.y = rsp.pos_y;
      p.head = rsp.heading;
      p.vel = rsp.fwd_velocity;
      p.turn = rsp.turn_term;
      odo.check(p);
    end
  end

  task automatic hold_off(int n);
    hold = 1;
    repeat (n) @(posedge clk);
    hold = 0;
  endtask

  task automatic send_report(report_t r);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      req.valid = 0;
    end
    @(negedge clk);
    req.valid = 1;
    req.fwd_disp_a = r.fa;
    req.fwd_disp_b = r.fb;
    req.left_disp_a = r.la;
    req.right_disp_a = r.ra;
    req.left_disp_b = r.lb;
    req.right_disp_b = r.rb;
    req.interval = r.dt;
    do @(posedge clk); while (!req.ready);
    odo.note(r);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid = 0;
    while (odo.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_width(bit [31:0] w);
    drain();
    @(negedge clk);
    cfg.valid = 1;
    cfg.track_width = w;
    do @(posedge clk); while (!cfg.ready);
    odo.width = w;
    @(negedge clk);
    cfg.valid = 0;
  endtask

  function automatic int pick_disp();
    case ($urandom_range(9))
      0: return int'($urandom);
      1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return int'($urandom_range(131072)) - 65536;
    endcase
  endfunction

  function automatic report_t pick_report();
    report_t r;
    r.fa = pick_disp();
    r.fb = $urandom_range(3) == 0 ? pick_disp() : r.fa;
    r.la = pick_disp();
    r.ra = $urandom_range(4) == 0 ? r.la : pick_disp();
    r.lb = pick_disp();
    r.rb = $urandom_range(4) == 0 ? r.lb : pick_disp();
    case ($urandom_range(9))
      0: r.dt = 24'($urandom_range(24'hFFFFFF, 1));
      1: r.dt = $urandom_range(1) ? 24'hFFFFFF : 24'd1;
      default: r.dt = 24'($urandom_range(6554, 1));
    endcase
    return r;
  endfunction

  function automatic report_t mk(int fa, int fb, int la, int ra, int lb, int rb,
                                 bit [23:0] dt);
    report_t r;
    r.fa = fa; r.fb = fb; r.la = la; r.ra = ra; r.lb = lb; r.rb = rb; r.dt = dt;
    return r;
  endfunction

  initial begin
    report_t   dir[$];
    bit [31:0] widths[4];
    int        gaps[4], stalls[4];
    odo.clear();
    hold = 0;
    gap_pct = 0;
    stall_pct = 0;
    cycles = 0;
    sent = 0;
    rst = 1;
    req.valid = 0;
    req.fwd_disp_a = 0; req.fwd_disp_b = 0;
    req.left_disp_a = 0; req.right_disp_a = 0;
    req.left_disp_b = 0; req.right_disp_b = 0;
    req.interval = 0;
    cfg.valid = 0;
    cfg.track_width = 0;
    rsp.ready = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    dir.push_back(mk(0, 0, 0, 0, 0, 0, 24'd655));
    dir.push_back(mk(65536, 65536, 0, 0, 0, 0, 24'd655));
    dir.push_back(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                     32'sh7FFFFFFF, 32'sh80000000, 24'hFFFFFF));
    dir.push_back(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                     32'sh80000000, 32'sh7FFFFFFF, 24'hFFFFFF));
    dir.push_back(mk(65536, 0, 0, 0, 0, 0, 24'd0));
    dir.push_back(mk(-65536, 0, 0, 0, 0, 0, 24'd0));
    dir.push_back(mk(0, 0, 6554, 0, 0, 0, 24'd0));
    dir.push_back(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0, 0, 24'd1));
    dir.push_back(mk(32'sh80000000, 32'sh80000000, 0, 0, 0, 0, 24'd1));
    dir.push_back(mk(65536, 65536, 20000, -20000, 20000, -20000, 24'hFFFFFF));
    dir.push_back(mk(65536, 65536, -20000, 20000, -20000, 20000, 24'hFFFFFF));
    dir.push_back(mk(3, -4, 1, 0, 0, 1, 24'd1));
    dir.push_back(mk(131072, 131072, 0, 65536, 0, 65536, 24'd65536));
    foreach (dir[i]) send_report(dir[i]);
    repeat (150) send_report(pick_report());

    widths = '{32'd1, 32'hFFFFFFFF, 32'd0, 32'd0};
    widths[3] = $urandom_range(65536, 4096);
    gaps = '{64, 0, 29, 0};
    stalls = '{0, 64, 29, 0};
    for (int ph = 0; ph < 4; ph++) begin
      write_width(widths[ph]);
      gap_pct = gaps[ph];
      stall_pct = stalls[ph];
      if (ph == 3) fork hold_off(4000); join_none
      // idle-free stretch in the middle of each phase
      for (int n = 0; n < 210; n++) begin
        if (n == 100) begin
          gap_pct = 0;
          stall_pct = 0;
        end
        if (n == 130) begin
          gap_pct = gaps[ph];
          stall_pct = stalls[ph];
        end
        send_report(pick_report());
      end
    end
    write_width(tbdro_pkg::TRACK_RESET);
    repeat (60) send_report(pick_report());

    @(negedge clk);
    req.valid = 0;
    drain();
    $display("sent %0d reports, checked %0d results over five track widths", sent,
             odo.checked);
    $display("including zero width, zero interval and a long output hold-off");
    if (odo.errors == 0 && odo.pending.size() == 0)
      $display("twin_base_dead_reckoning_odometry: match");
    else
      $display("twin_base_dead_reckoning_odometry: mismatch");
    $finish;
  end
endmodule
